// ===== hdl/rfc_pkg.sv =====
// Shared types, widths, register indexes and reset values for the row FIR filter.
package rfc_pkg;

  // Default sizing of the filter.
  localparam int MAX_TAPS_DEF = 8;
  localparam int MAX_ROW_DEF  = 4096;

  // Field widths.
  localparam int SAMPLE_W    = 8;
  localparam int TAP_WORD_W  = 64;
  localparam int TAP_COUNT_W = 4;
  localparam int ROW_CFG_W   = 13;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TAP_WORD    = 2'd0,
    REG_TAP_COUNT   = 2'd1,
    REG_ROW_STRIDE  = 2'd2,
    REG_IMAGE_WIDTH = 2'd3
  } reg_index_t;

  // Register values after reset.
  localparam logic [TAP_WORD_W-1:0]  TAP_WORD_RST    = 64'd1;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST   = 4'd1;
  localparam logic [ROW_CFG_W-1:0]   ROW_STRIDE_RST  = 13'd4096;
  localparam logic [ROW_CFG_W-1:0]   IMAGE_WIDTH_RST = 13'd4096;

endpackage

// ===== hdl/rfc_if.sv =====
// Request channel interfaces for the sample input and the filtered output.
interface rfc_in_if;
  import rfc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rfc_out_if;
  import rfc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    last_in_row;

  modport source (output valid, output filtered, output last_in_row, input ready);
  modport sink (input valid, input filtered, input last_in_row, output ready);
endinterface

// ===== hdl/row_fir_convolution.sv =====
// Row FIR convolution: horizontal valid-mode pass of a separable image filter.
//
// The block takes signed 8-bit samples in raster order, row_stride samples per
// row, and returns one filtered sample for every position where a full window
// of tap_count samples lies inside the row: the sum of sample times tap over the
// window, wrapped to 8 bits. A row yields min(image_width, row_stride) minus
// tap_count plus one results, and the last of them carries last_in_row. Rows
// too narrow for the window yield nothing. A request is taken every clock while
// input ready is high: the first register stage holds the sample history and
// the flags of the newest request, the second holds the result. A result is
// offered once it moves from the first stage into the output register.
// Input ready drops only while a result waits in the output register and the
// request in the first stage also has a result, so a stalled consumer holds
// back the producer one request later. There is no clearing pass after reset.
// Configuration is written through wr_en, wr_index and wr_data and should
// change only while no request is in flight.
module row_fir_convolution #(
  parameter int MAX_TAPS = rfc_pkg::MAX_TAPS_DEF,
  parameter int MAX_ROW  = rfc_pkg::MAX_ROW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  rfc_pkg::reg_index_t             wr_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]  wr_data,
  rfc_in_if.sink                          pixels,
  rfc_out_if.source                       results
);
  import rfc_pkg::*;

  // Width of the tap count after clamping, of a history index, of the column
  // counter, and of the compares between column and row limits.
  localparam int TAP_W   = $clog2(MAX_TAPS + 1);
  localparam int IDX_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int COL_W   = $clog2(MAX_ROW);
  localparam int LIM_W   = $clog2(MAX_ROW + 1);
  localparam int CMP_W   = ((ROW_CFG_W > LIM_W) ? ROW_CFG_W : LIM_W) + 1;

  // Configuration registers.
  logic [TAP_WORD_W-1:0]  tap_word;
  logic [TAP_COUNT_W-1:0] tap_count;
  logic [ROW_CFG_W-1:0]   row_stride;
  logic [ROW_CFG_W-1:0]   image_width;

  // Row position of the next sample.
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;

  // Sample history: hist[0] is the newest accepted sample. It doubles as the
  // first pipeline stage, since it only shifts when a new request enters.
  sample_t hist [MAX_TAPS];

  // First stage flags: a result is pending, whether it ends the row, and the
  // tap count it was computed for.
  logic             s1_pend;
  logic             s1_last;
  logic [TAP_W-1:0] s1_taps;

  // Output register.
  logic    out_valid;
  sample_t out_filtered;
  logic    out_last;

  logic             in_fire;
  logic             out_free;
  logic             emit;
  logic             last_col;
  logic [TAP_W-1:0] taps_eff;
  logic [CMP_W-1:0] stride_eff;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_ext;
  logic [CMP_W-1:0] col_p1;
  sample_t          sum_next;

  assign out_free     = !out_valid || results.ready;
  assign pixels.ready = !s1_pend || out_free;
  assign in_fire      = pixels.valid && pixels.ready;

  assign results.valid       = out_valid;
  assign results.filtered    = out_filtered;
  assign results.last_in_row = out_last;

  // Clamp the configuration to its legal range and decide whether the
  // incoming sample closes a window that lies inside the row. The window's
  // first column is column + 1 - taps, and it lies in the row exactly when that
  // first column is not negative and the column is below the effective width; the last window ends at that width.
  always_comb begin
    if (tap_count == '0) begin
      taps_eff = TAP_W'(1);
    end else if (TAP_COUNT_W'(tap_count) > TAP_COUNT_W'(MAX_TAPS)) begin
      taps_eff = TAP_W'(MAX_TAPS);
    end else begin
      taps_eff = TAP_W'(tap_count);
    end

    if (row_stride == '0) begin
      stride_eff = CMP_W'(1);
    end else if (CMP_W'(row_stride) > CMP_W'(MAX_ROW)) begin
      stride_eff = CMP_W'(MAX_ROW);
    end else begin
      stride_eff = CMP_W'(row_stride);
    end

    width_eff = (CMP_W'(image_width) < stride_eff) ? CMP_W'(image_width) : stride_eff;

    col_ext  = CMP_W'(column);
    col_p1   = col_ext + CMP_W'(1);
    emit     = (col_ext < width_eff) && (col_p1 >= CMP_W'(taps_eff));
    last_col = (col_p1 == width_eff);

    // A next column at or past the stride ends the row, which also covers a stride
    // lowered in the middle of a row.
    if (col_p1 >= stride_eff) begin
      column_next = '0;
    end else begin
      column_next = col_p1[COL_W-1:0];
    end
  end

  // Second stage: tap i weighs the sample taps-1-i places back in the history.
  // Only the low 8 bits of each product matter for the wrapped sum.
  always_comb begin
    logic [TAP_W-1:0]        back;
    logic signed [15:0]      prod;
    logic signed [7:0]       tap;
    sum_next = '0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      back = s1_taps - TAP_W'(1) - TAP_W'(i);
      tap  = tap_word[8*i +: 8];
      prod = 16'(tap) * 16'(hist[back[IDX_W-1:0]]);
      if (TAP_W'(i) < s1_taps) begin
        sum_next = sum_next + prod[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_word    <= TAP_WORD_RST;
      tap_count   <= TAP_COUNT_RST;
      row_stride  <= ROW_STRIDE_RST;
      image_width <= IMAGE_WIDTH_RST;
      column      <= '0;
      s1_pend     <= 1'b0;
      s1_last     <= 1'b0;
      s1_taps     <= TAP_W'(1);
      out_valid   <= 1'b0;
      for (int k = 0; k < MAX_TAPS; k++) begin
        hist[k] <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_TAP_WORD:    tap_word    <= wr_data[TAP_WORD_W-1:0];
          REG_TAP_COUNT:   tap_count   <= wr_data[TAP_COUNT_W-1:0];
          REG_ROW_STRIDE:  row_stride  <= wr_data[ROW_CFG_W-1:0];
          REG_IMAGE_WIDTH: image_width <= wr_data[ROW_CFG_W-1:0];
          default: ;
        endcase
      end

      // A pending result moves on whenever the output register frees up.
      if (s1_pend && out_free) begin
        out_valid    <= 1'b1;
        out_filtered <= sum_next;
        out_last     <= s1_last;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      if (in_fire) begin
        hist[0] <= pixels.sample;
        for (int k = 1; k < MAX_TAPS; k++) begin
          hist[k] <= hist[k-1];
        end
        column  <= column_next;
        s1_pend <= emit;
        s1_last <= last_col;
        s1_taps <= taps_eff;
      end else if (out_free) begin
        s1_pend <= 1'b0;
      end
    end
  end

endmodule
